// ===== design/finger_relative_joint_angles_top_defines.svh =====
// Assertion macros shared by the finger joint angle design.
// Included by the top-level module, which checks its own pipeline control.
`ifndef FINGER_RELATIVE_JOINT_ANGLES_TOP_DEFINES_SVH
`define FINGER_RELATIVE_JOINT_ANGLES_TOP_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define FRJA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define FRJA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/frja_pkg.sv =====
// Shared constants, widths and the arctangent table of the finger joint angle design.
// No dependencies; used by every module of the design.
`timescale 1ns / 1ps

package frja_pkg;

    localparam int NUM_JOINTS        = 4;
    localparam int IN_W              = 16;
    localparam int OUT_W             = 16;
    localparam int S_DATA_W          = 2 * NUM_JOINTS * IN_W;
    localparam int M_DATA_W          = (NUM_JOINTS - 1) * OUT_W;
    localparam int TABLE_LEN         = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    // Rotation datapath: 17-bit magnitude scaled by 2^16 plus CORDIC gain headroom.
    localparam int XY_W = 35;
    // Angle accumulator with 20 fraction bits.
    localparam int Z_W  = 25;
    // Scale of the inputs before rotation.
    localparam int PRE_SHIFT = 16;

    localparam logic signed [Z_W-1:0]   PI_ACC     = 25'sd3294199;
    localparam logic signed [Z_W-1:0]   ROUND_OFF  = 25'sd64;
    localparam int                      ROUND_SHIFT = 7;
    localparam logic signed [OUT_W:0]   PI_Q13     = 17'sd25736;
    localparam logic signed [OUT_W:0]   TWO_PI_Q13 = 17'sd51472;

    // atan(2^-i) scaled by 2^20, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 25'sd823550;
            1:       v = 25'sd486170;
            2:       v = 25'sd256879;
            3:       v = 25'sd130396;
            4:       v = 25'sd65451;
            5:       v = 25'sd32757;
            6:       v = 25'sd16383;
            7:       v = 25'sd8192;
            8:       v = 25'sd4096;
            9:       v = 25'sd2048;
            10:      v = 25'sd1024;
            11:      v = 25'sd512;
            12:      v = 25'sd256;
            13:      v = 25'sd128;
            14:      v = 25'sd64;
            15:      v = 25'sd32;
            16:      v = 25'sd16;
            17:      v = 25'sd8;
            18:      v = 25'sd4;
            19:      v = 25'sd2;
            20:      v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/frja_lane.sv =====
// One CORDIC lane: finds atan2(sin, cos) of one joint as a fully pipelined vectoring CORDIC.
// Depends on frja_pkg; the pipeline load enables come from the top-level control.
`timescale 1ns / 1ps

module frja_lane
    import frja_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                          clk,
    input  logic signed [IN_W-1:0]        cos_in,
    input  logic signed [IN_W-1:0]        sin_in,
    // Load enable of each register: entry, one per rotation, conversion.
    input  logic [((CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES) + 1:0] load,
    output logic signed [OUT_W-1:0]       angle
);

    localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    logic signed [XY_W-1:0] x_reg [NS+1];
    logic signed [XY_W-1:0] y_reg [NS+1];
    logic signed [Z_W-1:0]  z_reg [NS+1];
    logic                   zero_reg [NS+1];
    logic signed [OUT_W-1:0] angle_reg;

    // Entry: turn a vector in the left half-plane by 180 degrees and scale it up.
    logic                   neg;
    logic signed [IN_W:0]   x_abs;
    logic signed [IN_W:0]   y_abs;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;

    always_comb
    begin
        neg   = cos_in[IN_W-1];
        x_abs = neg ? -{cos_in[IN_W-1], cos_in} : {cos_in[IN_W-1], cos_in};
        y_abs = neg ? -{sin_in[IN_W-1], sin_in} : {sin_in[IN_W-1], sin_in};
        x_next = {{(XY_W-IN_W-1-PRE_SHIFT){x_abs[IN_W]}}, x_abs, {PRE_SHIFT{1'b0}}};
        y_next = {{(XY_W-IN_W-1-PRE_SHIFT){y_abs[IN_W]}}, y_abs, {PRE_SHIFT{1'b0}}};
        if (!neg)
        begin
            z_next = '0;
        end
        else if (!sin_in[IN_W-1])
        begin
            z_next = PI_ACC;
        end
        else
        begin
            z_next = -PI_ACC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (cos_in == '0) && (sin_in == '0);
        end
    end

    // Rotation stages: stage i drives the residual y toward zero with a shift of i.
    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_rot
            logic signed [XY_W-1:0] xs;
            logic signed [XY_W-1:0] ys;
            logic                   up;

            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;
            assign up = !y_reg[i][XY_W-1];

            always_ff @(posedge clk)
            begin
                if (load[i+1])
                begin
                    x_reg[i+1]    <= up ? x_reg[i] + ys : x_reg[i] - ys;
                    y_reg[i+1]    <= up ? y_reg[i] - xs : y_reg[i] + xs;
                    z_reg[i+1]    <= up ? z_reg[i] + atan_entry(i) : z_reg[i] - atan_entry(i);
                    zero_reg[i+1] <= zero_reg[i];
                end
            end
        end
    endgenerate

    // Conversion to Q3.13 with round half up and saturation to +/-pi; a zero vector gives angle 0.
    logic signed [Z_W-1:0]           z_round;
    logic signed [Z_W-ROUND_SHIFT-1:0] q;
    logic signed [OUT_W-1:0]         angle_next;

    always_comb
    begin
        z_round = z_reg[NS] + ROUND_OFF;
        q       = (Z_W-ROUND_SHIFT)'(z_round >>> ROUND_SHIFT);
        if (zero_reg[NS])
        begin
            angle_next = '0;
        end
        else if (q > (Z_W-ROUND_SHIFT)'(PI_Q13))
        begin
            angle_next = OUT_W'(PI_Q13);
        end
        else if (q < -(Z_W-ROUND_SHIFT)'(PI_Q13))
        begin
            angle_next = -OUT_W'(PI_Q13);
        end
        else
        begin
            angle_next = OUT_W'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[NS+1])
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// ===== design/frja_merge.sv =====
// Merge stage: differences of neighboring joint angles, wrapped once into [-pi, pi].
// Depends on frja_pkg; fed by the four CORDIC lanes.
`timescale 1ns / 1ps

module frja_merge
    import frja_pkg::*;
(
    input  logic                    clk,
    input  logic                    load,
    input  logic signed [OUT_W-1:0] angle [NUM_JOINTS],
    output logic [M_DATA_W-1:0]     rel_angles
);

    logic [M_DATA_W-1:0] out_reg;
    logic [M_DATA_W-1:0] out_next;

    // One subtract and one wrap per neighboring pair.
    always_comb
    begin
        logic signed [OUT_W:0] d;
        out_next = '0;
        for (int k = 0; k < NUM_JOINTS - 1; k++)
        begin
            d = {angle[k+1][OUT_W-1], angle[k+1]} - {angle[k][OUT_W-1], angle[k]};
            if (d > PI_Q13)
            begin
                d = d - TWO_PI_Q13;
            end
            else if (d < -PI_Q13)
            begin
                d = d + TWO_PI_Q13;
            end
            out_next[k*OUT_W +: OUT_W] = d[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign rel_angles = out_reg;

endmodule

// ===== design/finger_relative_joint_angles_top.sv =====
// An accepted input word passes through the entry register, one register per CORDIC rotation,
// the angle conversion register and the merge register on its way to the output.
// Throughput: one word per cycle while the output does not stall; the four joints run in four parallel CORDIC lanes.
// Stalls collapse bubbles stage by stage, so input is taken while a result waits as long as some stage is empty.
// Reset (rst_n low, asynchronous) clears only the valid bits of the pipeline.
`timescale 1ns / 1ps

`include "finger_relative_joint_angles_top_defines.svh"

module finger_relative_joint_angles_top
    import frja_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // From bit 0: cos_joint0, sin_joint0, cos_joint1, sin_joint1,
    // cos_joint2, sin_joint2, cos_joint3, sin_joint3 (16 bits each).
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // From bit 0: rel_angle_first, rel_angle_second, rel_angle_third (16 bits each).
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int NS   = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int LAST = NS + 1;

    logic [LAST:0]   valid_reg;
    logic [LAST:0]   valid_next;
    logic [LAST+1:0] ready;
    logic            out_valid_reg;
    logic            out_valid_next;

    logic signed [OUT_W-1:0] angle [NUM_JOINTS];

    // A stage may load when it is empty or its word moves on in the same cycle.
    assign ready[LAST+1] = !out_valid_reg || m_tready;

    genvar k;
    generate
        for (k = 0; k <= LAST; k++)
        begin : g_ready
            assign ready[k] = !valid_reg[k] || ready[k+1];
        end
    endgenerate

    always_comb
    begin
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int n = 1; n <= LAST; n++)
        begin
            valid_next[n] = ready[n] ? valid_reg[n-1] : valid_reg[n];
        end
        out_valid_next = ready[LAST+1] ? valid_reg[LAST] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // One CORDIC lane per joint, all moving in lockstep.
    genvar j;
    generate
        for (j = 0; j < NUM_JOINTS; j++)
        begin : g_lane
            frja_lane #(
                .CORDIC_STAGES (CORDIC_STAGES)
            ) u_lane (
                .clk    (clk),
                .cos_in (s_tdata[2*j*IN_W +: IN_W]),
                .sin_in (s_tdata[(2*j+1)*IN_W +: IN_W]),
                .load   (ready[LAST:0]),
                .angle  (angle[j])
            );
        end
    endgenerate

    frja_merge u_merge (
        .clk        (clk),
        .load       (ready[LAST+1]),
        .angle      (angle),
        .rel_angles (m_tdata)
    );

    assign s_tready = ready[0];
    assign m_tvalid = out_valid_reg;

    // An empty output register lets the whole pipeline take a new word.
    `FRJA_ASSERT_NOW(a_ready_when_out_empty, !m_tvalid, s_tready, "input stalled with empty output")
    // A finished lane word that moves on must show up at the output.
    `FRJA_ASSERT_NEXT(a_last_to_out, valid_reg[LAST] && ready[LAST+1], m_tvalid, "result lost")
    // An accepted input word occupies the entry stage next cycle.
    `FRJA_ASSERT_NEXT(a_accept_to_entry, s_tvalid && s_tready, valid_reg[0], "input word lost")
    // The first wrapped difference lies within [-pi, pi].
    `FRJA_ASSERT_NOW(a_first_range, m_tvalid, ($signed(m_tdata[15:0]) <= 16'sd25736) && ($signed(m_tdata[15:0]) >= -16'sd25736), "first angle out of range")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for finger_relative_joint_angles_top.
// It predicts the three relative joint angles of each input word with its own CORDIC model,
// checks every output word in order, and drives both stream sides with random gaps.
`timescale 1ns / 1ps

module tb_top
    import frja_pkg::*;
();

    localparam int ROT_STAGES   = 16;
    localparam int TABLED_STEPS = 24;
    localparam int RUN_STEPS    = (ROT_STAGES > TABLED_STEPS) ? TABLED_STEPS : ROT_STAGES;
    localparam int PIPE_LATENCY = ROT_STAGES + 3;

    localparam longint HALF_TURN_Q20 = 64'sd3294199;
    localparam int     HALF_TURN_Q13 = 25736;
    localparam int     FULL_TURN_Q13 = 51472;
    localparam int     IDLE_PERCENT  = 23;

    // Arctangent of 2^-i with 20 fraction bits.
    localparam int ATAN_Q20 [TABLED_STEPS] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    // Input word, highest bits first, so cos0 lands in bit 0 upward.
    typedef struct packed {
        logic signed [15:0] sin3;
        logic signed [15:0] cos3;
        logic signed [15:0] sin2;
        logic signed [15:0] cos2;
        logic signed [15:0] sin1;
        logic signed [15:0] cos1;
        logic signed [15:0] sin0;
        logic signed [15:0] cos0;
    } joint_set_t;

    // Output word, highest bits first.
    typedef struct packed {
        logic signed [15:0] rel_third;
        logic signed [15:0] rel_second;
        logic signed [15:0] rel_first;
    } angle_set_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    angle_set_t expected_angles [$];

    int  words_sent      = 0;
    int  results_checked = 0;
    int  failures        = 0;
    int  hold_off_cycles = 0;
    bit  sender_gaps     = 1'b1;
    bit  sink_gaps       = 1'b1;

    finger_relative_joint_angles_top #(
        .CORDIC_STAGES(ROT_STAGES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Absolute joint angle in Q3.13 from a vectoring CORDIC on (c, s).
    function automatic logic signed [15:0] joint_angle_q13(input logic signed [15:0] c,
                                                           input logic signed [15:0] s);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint q;
        x = longint'(c);
        y = longint'(s);
        z = 0;
        if (x == 0 && y == 0)
            return '0;
        // A vector in the left half plane is turned by a half turn first.
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN_Q20 : -HALF_TURN_Q20;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < RUN_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_Q20[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_Q20[i]);
            end
        end
        // Round half up into Q3.13, then clamp to plus or minus pi.
        q = (z + 64) >>> 7;
        if (q > HALF_TURN_Q13)
            q = HALF_TURN_Q13;
        else if (q < -HALF_TURN_Q13)
            q = -HALF_TURN_Q13;
        return q[15:0];
    endfunction

    // Difference of two angles, folded once into [-pi, pi].
    function automatic logic signed [15:0] folded_delta(input logic signed [15:0] ahead,
                                                        input logic signed [15:0] behind);
        int d;
        d = int'(ahead) - int'(behind);
        if (d > HALF_TURN_Q13)
            d = d - FULL_TURN_Q13;
        else if (d < -HALF_TURN_Q13)
            d = d + FULL_TURN_Q13;
        return d[15:0];
    endfunction

    function automatic angle_set_t relative_angles(input joint_set_t js);
        logic signed [15:0] a0;
        logic signed [15:0] a1;
        logic signed [15:0] a2;
        logic signed [15:0] a3;
        angle_set_t r;
        a0 = joint_angle_q13(js.cos0, js.sin0);
        a1 = joint_angle_q13(js.cos1, js.sin1);
        a2 = joint_angle_q13(js.cos2, js.sin2);
        a3 = joint_angle_q13(js.cos3, js.sin3);
        r.rel_first  = folded_delta(a1, a0);
        r.rel_second = folded_delta(a2, a1);
        r.rel_third  = folded_delta(a3, a2);
        return r;
    endfunction

    function automatic joint_set_t make_joints(
        input int c0, input int s0,
        input int c1, input int s1,
        input int c2, input int s2,
        input int c3, input int s3);
        joint_set_t js;
        js.cos0 = 16'(c0);
        js.sin0 = 16'(s0);
        js.cos1 = 16'(c1);
        js.sin1 = 16'(s1);
        js.cos2 = 16'(c2);
        js.sin2 = 16'(s2);
        js.cos3 = 16'(c3);
        js.sin3 = 16'(s3);
        return js;
    endfunction

    // One joint vector: fully random, corner values, tiny, or close to the negative x axis.
    function automatic void pick_joint(output logic signed [15:0] c,
                                       output logic signed [15:0] s);
        logic signed [15:0] corners [8];
        int mode;
        corners = '{16'sh0000, 16'sh0001, 16'shFFFF, 16'sh7FFF,
                    16'sh8000, 16'sh4000, 16'shC000, 16'sh2D41};
        mode = $urandom_range(99);
        if (mode < 40)
        begin
            c = 16'($urandom);
            s = 16'($urandom);
        end
        else if (mode < 60)
        begin
            c = corners[$urandom_range(7)];
            s = corners[$urandom_range(7)];
        end
        else if (mode < 75)
        begin
            c = 16'(int'($urandom_range(8)) - 4);
            s = 16'(int'($urandom_range(8)) - 4);
        end
        else
        begin
            c = 16'(-$signed({1'b0, 15'($urandom)}) - 1);
            s = 16'(int'($urandom_range(6)) - 3);
        end
    endfunction

    function automatic joint_set_t random_joints();
        joint_set_t js;
        pick_joint(js.cos0, js.sin0);
        pick_joint(js.cos1, js.sin1);
        pick_joint(js.cos2, js.sin2);
        pick_joint(js.cos3, js.sin3);
        return js;
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_joints(input joint_set_t js);
        while (sender_gaps && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {4{$urandom}};
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= js;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_angles.push_back(relative_angles(js));
        words_sent++;
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_angles.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_words(input int count);
        repeat (count)
            send_joints(random_joints());
    endtask

    // Zero vectors, axes, corners, the half-turn boundary and the difference fold.
    task automatic test_directed_cases();
        send_joints(make_joints(0, 0, 0, 0, 0, 0, 0, 0));
        send_joints(make_joints(16384, 0, 0, 16384, -16384, 0, 0, -16384));
        send_joints(make_joints(0, -16384, -16384, 0, 0, 16384, 16384, 0));
        send_joints(make_joints(-16384, 1, -16384, -1, -16384, 1, -16384, -1));
        send_joints(make_joints(-16384, -1, -16384, 1, -16384, -1, -16384, 1));
        send_joints(make_joints(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768));
        send_joints(make_joints(-32768, 0, -32768, 1, -32768, -1, -32768, -32768));
        send_joints(make_joints(0, 0, 32767, 0, 0, 0, -32768, 0));
        send_joints(make_joints(1, 0, 0, 1, -1, 0, 0, -1));
        send_joints(make_joints(1, 1, -1, -1, -1, 1, 1, -1));
        send_joints(make_joints(0, 32767, 0, -32768, 0, 32767, 0, -32768));
        send_joints(make_joints(-1, 0, -1, -1, -1, 0, -1, 1));
        send_joints(make_joints(32767, -1, 32767, 1, -32768, 32767, -32768, -32767));
        send_joints(make_joints(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768));
        send_joints(make_joints(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int count);
        send_random_words(count);
    endtask

    // A long stretch with no gaps on either side.
    task automatic test_back_to_back(input int count);
        sender_gaps = 1'b0;
        sink_gaps   = 1'b0;
        send_random_words(count);
        sender_gaps = 1'b1;
        sink_gaps   = 1'b1;
    endtask

    // The output stalls for a long time while input keeps coming, so the pipe fills up.
    task automatic test_output_hold_off(input int stall_len, input int count);
        sender_gaps     = 1'b0;
        hold_off_cycles = stall_len;
        send_random_words(count);
        sender_gaps     = 1'b1;
    endtask

    // Bursts separated by a full drain of the pipe.
    task automatic test_drain_and_resume(input int bursts, input int burst_len);
        repeat (bursts)
        begin
            send_random_words(burst_len);
            wait_for_drain();
        end
    endtask

    // Output side: random or held-off ready.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_off_cycles--;
            end
            else if (sink_gaps)
                m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
            else
                m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string label, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= 10)
                $display("MISMATCH %s after %0d results: expected %0d, got %0d",
                         label, results_checked, want, got);
        end
    endtask

    // Compare each output word with the oldest prediction.
    always @(posedge clk)
    begin
        angle_set_t got;
        angle_set_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = angle_set_t'(m_tdata);
            if (expected_angles.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("MISMATCH unexpected output word %h", m_tdata);
            end
            else
            begin
                want = expected_angles.pop_front();
                check_field("rel_angle_first", want.rel_first, got.rel_first);
                check_field("rel_angle_second", want.rel_second, got.rel_second);
                check_field("rel_angle_third", want.rel_third, got.rel_third);
                results_checked++;
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(450);
        test_back_to_back(200);
        test_output_hold_off(120, 60);
        test_drain_and_resume(4, 30);
        test_random_traffic(360);

        wait_for_drain();
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (expected_angles.size() != 0)
        begin
            failures++;
            $display("MISSING %0d output words never arrived", expected_angles.size());
        end
        $display("Summary: %0d joint words sent, %0d angle words checked, %0d failures.",
                 words_sent, results_checked, failures);
        $display("Covered zero vectors, axes, corners, half-turn fold, stalls and drains.");
        if (failures == 0)
            $display("finger_relative_joint_angles_top test passed");
        else
            $display("finger_relative_joint_angles_top test failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d output words outstanding.", expected_angles.size());
        $display("finger_relative_joint_angles_top test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/frja_pkg.sv
design/frja_lane.sv
design/frja_merge.sv
design/finger_relative_joint_angles_top.sv
tb/tb_top.sv
